// ===== src/mcb_pkg.sv =====
package mcb_pkg;

    localparam int REG_W   = 13;
    localparam int IDX_W   = 3;
    localparam int PIX_W   = 32;
    localparam int COORD_W = 12;

    // register indexes on the config port
    localparam logic [IDX_W-1:0] REG_OFFSET_X      = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET_Y      = 3'd1;
    localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] REG_DEST_WIDTH    = 3'd4;
    localparam logic [IDX_W-1:0] REG_DEST_HEIGHT   = 3'd5;

    // mask color bits all set: leave the destination untouched
    localparam logic [23:0] KEEP_PATTERN = 24'hFF_FFFF;

    typedef struct packed {
        logic [REG_W-1:0] offset_x;
        logic [REG_W-1:0] offset_y;
        logic [REG_W-1:0] source_width;
        logic [REG_W-1:0] source_height;
        logic [REG_W-1:0] dest_width;
        logic [REG_W-1:0] dest_height;
    } t_cfg;

endpackage

// ===== src/mcb_cfg_regs.sv =====
module mcb_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mcb_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [mcb_pkg::REG_W-1:0]   i_cfg_data,
    output mcb_pkg::t_cfg               o_cfg
);

    mcb_pkg::t_cfg r_cfg;
    mcb_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mcb_pkg::REG_OFFSET_X:      n_cfg.offset_x      = i_cfg_data;
                mcb_pkg::REG_OFFSET_Y:      n_cfg.offset_y      = i_cfg_data;
                mcb_pkg::REG_SOURCE_WIDTH:  n_cfg.source_width  = i_cfg_data;
                mcb_pkg::REG_SOURCE_HEIGHT: n_cfg.source_height = i_cfg_data;
                mcb_pkg::REG_DEST_WIDTH:    n_cfg.dest_width    = i_cfg_data;
                mcb_pkg::REG_DEST_HEIGHT:   n_cfg.dest_height   = i_cfg_data;
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x      <= '0;
            r_cfg.offset_y      <= '0;
            r_cfg.source_width  <= mcb_pkg::REG_W'(1);
            r_cfg.source_height <= mcb_pkg::REG_W'(1);
            r_cfg.dest_width    <= mcb_pkg::REG_W'(1);
            r_cfg.dest_height   <= mcb_pkg::REG_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== src/masked_clipped_blit.sv =====
// Masked, clipped blit. Source pixels arrive on the slave stream in raster
// order, each beat carrying the source pixel and its mask pixel. The block
// tracks column and row over the source frame (wrapping at the frame end,
// never reset by a register write) and places each pixel at
// (column + offset_x, row + offset_y). A write beat goes out only when that
// point lies inside the destination and the mask's low 24 bits are not all
// ones; everything else is dropped silently. Size registers of zero act as
// one and sizes above MAX_SIDE act as MAX_SIDE. One beat is taken every clock
// while m_axis is not stalled; it passes the input register, then the output
// register. Write configuration only while no beat is in flight.
module masked_clipped_blit #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [63:0]                 s_axis_tdata,   // source_pixel, mask_pixel
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [55:0]                 m_axis_tdata,   // write_x, write_y, write_pixel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mcb_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [mcb_pkg::REG_W-1:0]   i_cfg_data
);

    localparam int REG_W = mcb_pkg::REG_W;
    localparam int CW    = $clog2(MAX_SIDE);
    localparam int AW    = ((CW > REG_W) ? CW : REG_W) + 2;

    mcb_pkg::t_cfg cfg;

    mcb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    function automatic logic [REG_W-1:0] eff_size(input logic [REG_W-1:0] v);
        logic [REG_W-1:0] s;
        s = v;
        if (v == '0)
            s = REG_W'(1);
        else if (32'(v) > MAX_SIDE)
            s = REG_W'(MAX_SIDE);
        return s;
    endfunction

    logic [REG_W-1:0] sw, sh, dw, dh;
    assign sw = eff_size(cfg.source_width);
    assign sh = eff_size(cfg.source_height);
    assign dw = eff_size(cfg.dest_width);
    assign dh = eff_size(cfg.dest_height);

    // raster counters
    logic [CW-1:0] r_col, n_col, r_row, n_row;
    logic          s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (s_acc) begin
            if (AW'(r_col) + AW'(1) >= AW'(sw)) begin
                n_col = '0;
                if (AW'(r_row) + AW'(1) >= AW'(sh))
                    n_row = '0;
                else
                    n_row = r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    // input stage
    logic                       r_s1_valid;
    logic [CW-1:0]              r_s1_col, r_s1_row;
    logic [mcb_pkg::PIX_W-1:0]  r_s1_pixel;
    logic                       r_s1_paint;

    // output stage
    logic                       r_o_valid, n_o_valid;
    logic [mcb_pkg::COORD_W-1:0] r_o_x, r_o_y;
    logic [mcb_pkg::PIX_W-1:0]  r_o_pixel;

    logic out_free, s1_free;
    assign out_free      = !r_o_valid || m_axis_tready;
    assign s1_free       = !r_s1_valid || out_free;
    assign s_axis_tready = s1_free;

    logic signed [AW-1:0] dx, dy;
    logic                 in_dest;

    assign dx = $signed(AW'(r_s1_col))
              + $signed({{(AW-REG_W){cfg.offset_x[REG_W-1]}}, cfg.offset_x});
    assign dy = $signed(AW'(r_s1_row))
              + $signed({{(AW-REG_W){cfg.offset_y[REG_W-1]}}, cfg.offset_y});
    assign in_dest = !dx[AW-1] && !dy[AW-1]
                  && (AW'(dx) < AW'(dw)) && (AW'(dy) < AW'(dh));

    always_comb begin
        n_o_valid = r_o_valid;
        if (out_free)
            n_o_valid = r_s1_valid && in_dest && r_s1_paint;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_o_valid <= n_o_valid;
            if (s1_free)
                r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
            r_s1_pixel <= s_axis_tdata[31:0];
            r_s1_paint <= s_axis_tdata[55:32] != mcb_pkg::KEEP_PATTERN;
        end
        if (out_free) begin
            r_o_x     <= dx[mcb_pkg::COORD_W-1:0];
            r_o_y     <= dy[mcb_pkg::COORD_W-1:0];
            r_o_pixel <= r_s1_pixel;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_pixel, r_o_y, r_o_x};

endmodule

// ===== src/mcb_checker.sv =====
module mcb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    // a stalled write beat keeps its data
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("write beat changed while stalled");

    // reset empties the pipeline
    assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("write beat shown right after reset");

    // no beat taken in and output empty: nothing can come out next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("write beat without a source beat");

endmodule

bind masked_clipped_blit mcb_checker u_mcb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
